>>> hw/rtl/bnlj_pkg.sv
package bnlj_pkg;

   // field widths fixed by the record format
   localparam int KEY_W   = 32;
   localparam int REF_W   = 32;
   localparam int CMD_W   = 2;
   localparam int LIMIT_W = 6;

   // default block depth and limit register reset value
   localparam int             BLOCK_ENTRIES_DEF = 32;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 6'd32;

   // command codes on the request channel
   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PROBE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // result kinds
   localparam logic KIND_ROW    = 1'b0;
   localparam logic KIND_REJECT = 1'b1;

   // work handed from front to back
   typedef enum logic [1:0] {
      OP_WRITE,
      OP_REJECT,
      OP_PROBE
   } op_type;

   localparam int OP_W = 2;

   // back-end sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

>>> hw/rtl/bnlj_queue.sv
module bnlj_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   // two-entry fifo
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       fill_ff;
   logic [1:0]       fill_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (fill_ff == 2'd2);
   assign empty    = (fill_ff == 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/bnlj_front.sv
module bnlj_front #(
   parameter int BLOCK_ENTRIES = 32,
   parameter int CW = 6,
   parameter int QW = 136
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [bnlj_pkg::CMD_W-1:0]      req_cmd,
   input  logic signed [bnlj_pkg::KEY_W-1:0] req_join_key,
   input  logic [bnlj_pkg::REF_W-1:0]      req_name_ref,
   input  logic signed [bnlj_pkg::KEY_W-1:0] req_order_id,
   input  logic [bnlj_pkg::REF_W-1:0]      req_comment_ref,
   input  logic                            csr_valid,
   input  logic [bnlj_pkg::LIMIT_W-1:0]    csr_block_limit,
   output logic                            q_push,
   output logic [QW-1:0]                   q_push_data,
   input  logic                            q_full
);

   import bnlj_pkg::*;

   localparam int CMP_W = LIMIT_W + 1;
   localparam logic [CMP_W-1:0] MAX_LIM = CMP_W'(BLOCK_ENTRIES);

   logic [LIMIT_W-1:0] limit_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic [CMP_W-1:0]   eff_limit;
   logic               block_full;
   logic               accept;
   op_type             op;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // zero or oversized limit means the whole block
   always_comb begin
      if (limit_ff == '0 || CMP_W'(limit_ff) > MAX_LIM) begin
         eff_limit = MAX_LIM;
      end else begin
         eff_limit = CMP_W'(limit_ff);
      end
   end

   assign block_full = (CMP_W'(count_ff) >= eff_limit);

   // classify the beat and track the fill count
   always_comb begin
      count_in = count_ff;
      q_push   = 1'b0;
      op       = OP_PROBE;
      if (accept) begin
         unique case (req_cmd)
            CMD_LOAD: begin
               q_push = 1'b1;
               if (block_full) begin
                  op = OP_REJECT;
               end else begin
                  op       = OP_WRITE;
                  count_in = count_ff + CW'(1);
               end
            end
            CMD_PROBE: begin
               q_push = 1'b1;
               op     = OP_PROBE;
            end
            CMD_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   // write entries carry the slot, probes carry the count to scan
   assign q_push_data = {OP_W'(op), count_ff, req_join_key, req_name_ref,
                         req_order_id, req_comment_ref};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         limit_ff <= LIMIT_RESET;
      end else begin
         count_ff <= count_in;
         if (csr_valid) begin
            limit_ff <= csr_block_limit;
         end
      end
   end

endmodule

>>> hw/rtl/bnlj_back.sv
module bnlj_back #(
   parameter int BLOCK_ENTRIES = 32,
   parameter int CW = 6,
   parameter int QW = 136
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [QW-1:0]                     q_pop_data,
   input  logic                              q_empty,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_kind,
   output logic signed [bnlj_pkg::KEY_W-1:0] rsp_match_key,
   output logic [bnlj_pkg::REF_W-1:0]        rsp_match_name_ref,
   output logic signed [bnlj_pkg::KEY_W-1:0] rsp_match_order_id,
   output logic [bnlj_pkg::REF_W-1:0]        rsp_match_comment_ref,
   output logic                              rsp_last
);

   import bnlj_pkg::*;

   localparam int AW = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;

   // queue entry fields
   op_type             q_op;
   logic [OP_W-1:0]    q_op_bits;
   logic [CW-1:0]      q_cnt;
   logic [KEY_W-1:0]   q_key;
   logic [REF_W-1:0]   q_name;
   logic [KEY_W-1:0]   q_order;
   logic [REF_W-1:0]   q_comment;

   assign {q_op_bits, q_cnt, q_key, q_name, q_order, q_comment} = q_pop_data;
   assign q_op = op_type'(q_op_bits);

   // entry store
   logic [KEY_W-1:0] key_mem  [BLOCK_ENTRIES];
   logic [REF_W-1:0] name_mem [BLOCK_ENTRIES];
   logic [KEY_W-1:0] key_q_ff;
   logic [REF_W-1:0] name_q_ff;
   logic             mem_we;
   logic             rd_en;

   // sequencer and probe context
   state_type        state_ff, state_in;
   logic [CW-1:0]    rd_idx_ff, rd_idx_in;
   logic             dv_ff, dv_in;
   logic             pend_vld_ff, pend_vld_in;
   logic [REF_W-1:0] pend_name_ff, pend_name_in;
   logic             probe_load;
   logic [CW-1:0]    pr_cnt_ff;
   logic [KEY_W-1:0] pr_key_ff;
   logic [KEY_W-1:0] pr_order_ff;
   logic [REF_W-1:0] pr_comment_ff;
   logic             hit;

   // output register
   logic             out_vld_ff, out_vld_in;
   logic             out_load;
   logic             out_free;
   logic             o_kind_ff, o_kind_in;
   logic [KEY_W-1:0] o_key_ff, o_key_in;
   logic [REF_W-1:0] o_name_ff, o_name_in;
   logic [KEY_W-1:0] o_order_ff, o_order_in;
   logic [REF_W-1:0] o_comment_ff, o_comment_in;
   logic             o_last_ff, o_last_in;

   assign out_free = !out_vld_ff || !rsp_stall;
   assign hit      = dv_ff && (key_q_ff == pr_key_ff);

   // sequencer: writes, rejects and a one-entry-per-cycle probe scan that rsp_stall can hold
   always_comb begin
      state_in     = state_ff;
      rd_idx_in    = rd_idx_ff;
      dv_in        = dv_ff;
      pend_vld_in  = pend_vld_ff;
      pend_name_in = pend_name_ff;
      probe_load   = 1'b0;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      out_load     = 1'b0;
      o_kind_in    = KIND_ROW;
      o_key_in     = pr_key_ff;
      o_name_in    = pend_name_ff;
      o_order_in   = pr_order_ff;
      o_comment_in = pr_comment_ff;
      o_last_in    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               unique case (q_op)
                  OP_WRITE: begin
                     q_pop  = 1'b1;
                     mem_we = 1'b1;
                  end
                  OP_REJECT: begin
                     if (out_free) begin
                        q_pop        = 1'b1;
                        out_load     = 1'b1;
                        o_kind_in    = KIND_REJECT;
                        o_key_in     = q_key;
                        o_name_in    = q_name;
                        o_order_in   = '0;
                        o_comment_in = '0;
                        o_last_in    = 1'b1;
                     end
                  end
                  OP_PROBE: begin
                     q_pop       = 1'b1;
                     probe_load  = 1'b1;
                     rd_idx_in   = '0;
                     dv_in       = 1'b0;
                     pend_vld_in = 1'b0;
                     state_in    = ST_SCAN;
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (!dv_ff && rd_idx_ff == pr_cnt_ff) begin
               // scan drained: flush the held row as the last one
               if (!pend_vld_ff) begin
                  state_in = ST_IDLE;
               end else if (out_free) begin
                  out_load    = 1'b1;
                  o_last_in   = 1'b1;
                  pend_vld_in = 1'b0;
                  state_in    = ST_IDLE;
               end
            end else if (!(hit && pend_vld_ff) || out_free) begin
               // a new hit pushes the held row out
               if (hit) begin
                  out_load     = pend_vld_ff;
                  pend_vld_in  = 1'b1;
                  pend_name_in = name_q_ff;
               end
               if (rd_idx_ff != pr_cnt_ff) begin
                  rd_en     = 1'b1;
                  rd_idx_in = rd_idx_ff + CW'(1);
                  dv_in     = 1'b1;
               end else begin
                  dv_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      out_vld_in = out_load ? 1'b1 : (out_vld_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         dv_ff       <= 1'b0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         rd_idx_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         dv_ff       <= dv_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
         rd_idx_ff   <= rd_idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_name_ff <= pend_name_in;
      if (probe_load) begin
         pr_cnt_ff     <= q_cnt;
         pr_key_ff     <= q_key;
         pr_order_ff   <= q_order;
         pr_comment_ff <= q_comment;
      end
      if (out_load) begin
         o_kind_ff    <= o_kind_in;
         o_key_ff     <= o_key_in;
         o_name_ff    <= o_name_in;
         o_order_ff   <= o_order_in;
         o_comment_ff <= o_comment_in;
         o_last_ff    <= o_last_in;
      end
   end

   // entry store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[q_cnt[AW-1:0]]  <= q_key;
         name_mem[q_cnt[AW-1:0]] <= q_name;
      end
      if (rd_en) begin
         key_q_ff  <= key_mem[rd_idx_ff[AW-1:0]];
         name_q_ff <= name_mem[rd_idx_ff[AW-1:0]];
      end
   end

   assign rsp_valid             = out_vld_ff;
   assign rsp_kind              = o_kind_ff;
   assign rsp_match_key         = o_key_ff;
   assign rsp_match_name_ref    = o_name_ff;
   assign rsp_match_order_id    = o_order_ff;
   assign rsp_match_comment_ref = o_comment_ff;
   assign rsp_last              = o_last_ff;

endmodule

>>> hw/rtl/block_nested_loop_join.sv
// channel | dir | handshake          | beat
// req     | in  | req_valid/stall    | command, join key, name, order, comment
// rsp     | out | rsp_valid/stall    | kind, key, name, order, comment, last
// csr     | in  | csr_valid/ready    | block limit
//
// loads and rejects need no scan in the back end; clears never reach it.
// a probe scans the entry store one stored entry per cycle through its
// registered read port, unless a stalled rsp beat holds the scan.
// reset is synchronous; it empties the block and sets the limit to 32.
// a two-entry queue parts front and back; req_stall rises only when it is full,
// and a stalled rsp beat holds the scan once a second hit is waiting.
module block_nested_loop_join #(
   parameter int BLOCK_ENTRIES = bnlj_pkg::BLOCK_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bnlj_pkg::CMD_W-1:0]        req_cmd,
   input  logic signed [bnlj_pkg::KEY_W-1:0] req_join_key,
   input  logic [bnlj_pkg::REF_W-1:0]        req_name_ref,
   input  logic signed [bnlj_pkg::KEY_W-1:0] req_order_id,
   input  logic [bnlj_pkg::REF_W-1:0]        req_comment_ref,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_kind,
   output logic signed [bnlj_pkg::KEY_W-1:0] rsp_match_key,
   output logic [bnlj_pkg::REF_W-1:0]        rsp_match_name_ref,
   output logic signed [bnlj_pkg::KEY_W-1:0] rsp_match_order_id,
   output logic [bnlj_pkg::REF_W-1:0]        rsp_match_comment_ref,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bnlj_pkg::LIMIT_W-1:0]      csr_block_limit
);

   import bnlj_pkg::*;

   localparam int CW = $clog2(BLOCK_ENTRIES + 1);
   localparam int QW = OP_W + CW + 2 * KEY_W + 2 * REF_W;

   logic          q_push;
   logic [QW-1:0] q_push_data;
   logic          q_full;
   logic          q_pop;
   logic [QW-1:0] q_pop_data;
   logic          q_empty;

   assign csr_ready = 1'b1;

   // front: limit register, fill count, classification
   bnlj_front #(
      .BLOCK_ENTRIES(BLOCK_ENTRIES),
      .CW(CW),
      .QW(QW)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_join_key(req_join_key),
      .req_name_ref(req_name_ref),
      .req_order_id(req_order_id),
      .req_comment_ref(req_comment_ref),
      .csr_valid(csr_valid),
      .csr_block_limit(csr_block_limit),
      .q_push(q_push),
      .q_push_data(q_push_data),
      .q_full(q_full)
   );

   // work queue between front and back
   bnlj_queue #(
      .WIDTH(QW)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_data(q_push_data),
      .full(q_full),
      .pop(q_pop),
      .pop_data(q_pop_data),
      .empty(q_empty)
   );

   // back: entry store, probe scan, result register
   bnlj_back #(
      .BLOCK_ENTRIES(BLOCK_ENTRIES),
      .CW(CW),
      .QW(QW)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_pop_data(q_pop_data),
      .q_empty(q_empty),
      .q_pop(q_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_match_key(rsp_match_key),
      .rsp_match_name_ref(rsp_match_name_ref),
      .rsp_match_order_id(rsp_match_order_id),
      .rsp_match_comment_ref(rsp_match_comment_ref),
      .rsp_last(rsp_last)
   );

endmodule

>>> sim/tb_block_nested_loop_join.sv
module tb_block_nested_loop_join;
   import bnlj_pkg::*;

   localparam int DRAIN_CYCLES = 150;
   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_PCT     = 27;
   localparam int MAX_PRINTS   = 50;

   localparam logic [CMD_W-1:0]        CMD_UNUSED = 2'd3;
   localparam logic signed [KEY_W-1:0] KEY_MIN    = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX    = 32'sh7fff_ffff;

   // one joined row or reject status as seen on the rsp channel
   typedef struct {
      logic                    kind;
      logic signed [KEY_W-1:0] key;
      logic [REF_W-1:0]        name_ref;
      logic signed [KEY_W-1:0] order_id;
      logic [REF_W-1:0]        comment_ref;
      logic                    last;
   } join_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [CMD_W-1:0]        req_cmd = CMD_CLEAR;
   logic signed [KEY_W-1:0] req_join_key = '0;
   logic [REF_W-1:0]        req_name_ref = '0;
   logic signed [KEY_W-1:0] req_order_id = '0;
   logic [REF_W-1:0]        req_comment_ref = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_kind;
   logic signed [KEY_W-1:0] rsp_match_key;
   logic [REF_W-1:0]        rsp_match_name_ref;
   logic signed [KEY_W-1:0] rsp_match_order_id;
   logic [REF_W-1:0]        rsp_match_comment_ref;
   logic                    rsp_last;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [LIMIT_W-1:0]      csr_block_limit = '0;

   // predictor state: customer store, fill count and limit register
   logic signed [KEY_W-1:0] cust_keys [BLOCK_ENTRIES_DEF];
   logic [REF_W-1:0]        cust_names [BLOCK_ENTRIES_DEF];
   int unsigned             cust_count = 0;
   logic [LIMIT_W-1:0]      limit_reg = LIMIT_RESET;

   join_row_type rows_due[$];

   // pacing controls for both channels
   logic rsp_hold = 1'b0;
   logic steady = 1'b0;

   int errors = 0;
   int n_loads = 0, n_probes = 0, n_clears = 0, n_ignored = 0;
   int n_rows = 0, n_rejects = 0, n_limit_writes = 0;

   block_nested_loop_join DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_cmd               (req_cmd),
      .req_join_key          (req_join_key),
      .req_name_ref          (req_name_ref),
      .req_order_id          (req_order_id),
      .req_comment_ref       (req_comment_ref),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_kind              (rsp_kind),
      .rsp_match_key         (rsp_match_key),
      .rsp_match_name_ref    (rsp_match_name_ref),
      .rsp_match_order_id    (rsp_match_order_id),
      .rsp_match_comment_ref (rsp_match_comment_ref),
      .rsp_last              (rsp_last),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_block_limit       (csr_block_limit)
   );

   always #5 clock = ~clock;

   // generous run limit
   initial begin
      #5_000_000;
      $display("timeout with %0d rows still expected", rows_due.size());
      $display("== FAIL ==");
      $finish;
   end

   task automatic report_mismatch(input string what);
      errors++;
      if (errors <= MAX_PRINTS)
         $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // append one row to the tail of the expected list
   function automatic void expect_row(input join_row_type row);
      rows_due.insert(rows_due.size(), row);
   endfunction

   // expected rows for one accepted command; updates the customer store
   function automatic void predict_join(input logic [CMD_W-1:0] cmd,
                                        input logic signed [KEY_W-1:0] key,
                                        input logic [REF_W-1:0] name,
                                        input logic signed [KEY_W-1:0] order,
                                        input logic [REF_W-1:0] comment);
      int unsigned  cap;
      int           first_row;
      join_row_type row;
      cap = (limit_reg == 0 || limit_reg > BLOCK_ENTRIES_DEF) ? BLOCK_ENTRIES_DEF : limit_reg;
      case (cmd)
         CMD_LOAD: begin
            if (cust_count >= cap) begin
               row.kind        = KIND_REJECT;
               row.key         = key;
               row.name_ref    = name;
               row.order_id    = '0;
               row.comment_ref = '0;
               row.last        = 1'b1;
               expect_row(row);
            end else begin
               cust_keys[cust_count]  = key;
               cust_names[cust_count] = name;
               cust_count++;
            end
         end
         CMD_PROBE: begin
            first_row = rows_due.size();
            for (int i = 0; i < cust_count; i++) begin
               if (cust_keys[i] == key) begin
                  row.kind        = KIND_ROW;
                  row.key         = cust_keys[i];
                  row.name_ref    = cust_names[i];
                  row.order_id    = order;
                  row.comment_ref = comment;
                  row.last        = 1'b0;
                  expect_row(row);
               end
            end
            if (rows_due.size() > first_row)
               rows_due[rows_due.size()-1].last = 1'b1;
         end
         CMD_CLEAR: cust_count = 0;
         default: ;
      endcase
   endfunction

   // compare one accepted rsp beat with the oldest expected row
   task automatic check_row();
      join_row_type want;
      if (rows_due.size() == 0) begin
         report_mismatch($sformatf("unexpected beat kind %0d key %h", rsp_kind, rsp_match_key));
         return;
      end
      want = rows_due.pop_front();
      if (rsp_kind == KIND_REJECT) n_rejects++; else n_rows++;
      if (rsp_kind !== want.kind)
         report_mismatch($sformatf("kind %0d, expected %0d", rsp_kind, want.kind));
      if (rsp_match_key !== want.key)
         report_mismatch($sformatf("key %h, expected %h", rsp_match_key, want.key));
      if (rsp_match_name_ref !== want.name_ref)
         report_mismatch($sformatf("name %h, expected %h", rsp_match_name_ref, want.name_ref));
      if (rsp_match_order_id !== want.order_id)
         report_mismatch($sformatf("order %h, expected %h", rsp_match_order_id, want.order_id));
      if (rsp_match_comment_ref !== want.comment_ref)
         report_mismatch($sformatf("comment %h, expected %h",
                                   rsp_match_comment_ref, want.comment_ref));
      if (rsp_last !== want.last)
         report_mismatch($sformatf("last %0d, expected %0d", rsp_last, want.last));
   endtask

   // result side: check accepted beats, then pick the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_row();
         rsp_stall <= rsp_hold || (!steady && $urandom_range(99) < IDLE_PCT);
      end
   end

   // offer one command beat and wait until it is taken
   task automatic send_item(input logic [CMD_W-1:0] cmd,
                            input logic signed [KEY_W-1:0] key,
                            input logic [REF_W-1:0] name,
                            input logic signed [KEY_W-1:0] order,
                            input logic [REF_W-1:0] comment);
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_join_key    <= key;
      req_name_ref    <= name;
      req_order_id    <= order;
      req_comment_ref <= comment;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (cmd)
         CMD_LOAD:  n_loads++;
         CMD_PROBE: n_probes++;
         CMD_CLEAR: n_clears++;
         default:   n_ignored++;
      endcase
      predict_join(cmd, key, name, order, comment);
   endtask

   // let every expected row arrive and the back end go quiet
   task automatic settle_block();
      req_valid <= 1'b0;
      while (rows_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      settle_block();
      csr_valid       <= 1'b1;
      csr_block_limit <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      limit_reg = value;
      n_limit_writes++;
   endtask

   // hold the result side off for a fixed stretch
   task automatic hold_results(input int cycles);
      rsp_hold <= 1'b1;
      repeat (cycles) @(posedge clock);
      rsp_hold <= 1'b0;
   endtask

   // probe and clear on an empty block, unused command
   task automatic test_empty_block();
      send_item(CMD_PROBE, 32'sd5, 32'h0, 32'sd1, 32'h0);
      send_item(CMD_UNUSED, 32'sd0, 32'hffff_ffff, KEY_MAX, 32'hffff_ffff);
      send_item(CMD_CLEAR, KEY_MIN, 32'h0, 32'sd0, 32'h0);
   endtask

   // key and handle extremes, duplicate keys, probe with no match
   task automatic test_load_and_probe();
      send_item(CMD_LOAD, KEY_MIN, 32'h0000_0000, 32'sd0, 32'h0);
      send_item(CMD_LOAD, KEY_MAX, 32'hffff_ffff, 32'sd0, 32'h0);
      send_item(CMD_LOAD, -32'sd1, 32'ha5a5_a5a5, 32'sd0, 32'h0);
      send_item(CMD_LOAD, KEY_MAX, 32'h1234_5678, 32'sd0, 32'h0);
      send_item(CMD_LOAD, 32'sd0, 32'h5a5a_5a5a, 32'sd0, 32'h0);
      send_item(CMD_PROBE, KEY_MAX, 32'h0, KEY_MIN, 32'h0000_0000);
      send_item(CMD_PROBE, KEY_MIN, 32'h0, KEY_MAX, 32'hffff_ffff);
      send_item(CMD_PROBE, -32'sd1, 32'h0, -32'sd1, 32'h8000_0001);
      send_item(CMD_PROBE, 32'sd0, 32'h0, 32'sd0, 32'h7fff_fffe);
      send_item(CMD_PROBE, 32'sd7, 32'h0, 32'sd9, 32'h1);
   endtask

   // limit below count, one entry, zero and oversized limits
   task automatic test_limit_settings();
      write_limit(6'd2);
      send_item(CMD_LOAD, 32'sd11, 32'hffff_0000, 32'sd0, 32'h0);
      send_item(CMD_PROBE, KEY_MAX, 32'h0, 32'sd3, 32'hc0de_0001);
      send_item(CMD_CLEAR, 32'sd0, 32'h0, 32'sd0, 32'h0);
      write_limit(6'd1);
      send_item(CMD_LOAD, 32'sd4, 32'h0000_0004, 32'sd0, 32'h0);
      send_item(CMD_LOAD, 32'sd4, 32'h0000_0005, 32'sd0, 32'h0);
      send_item(CMD_PROBE, 32'sd4, 32'h0, 32'sd44, 32'h0000_0444);
      write_limit(6'd0);
      send_item(CMD_LOAD, 32'sd4, 32'h0000_0006, 32'sd0, 32'h0);
      write_limit(6'd63);
      send_item(CMD_LOAD, 32'sd4, 32'h0000_0007, 32'sd0, 32'h0);
      send_item(CMD_PROBE, 32'sd4, 32'h0, -32'sd44, 32'h0000_0555);
      send_item(CMD_CLEAR, 32'sd0, 32'h0, 32'sd0, 32'h0);
   endtask

   // fill the whole block with one key and probe it while results are held off
   task automatic test_block_full_pressure();
      write_limit(LIMIT_RESET);
      send_item(CMD_CLEAR, 32'sd0, 32'h0, 32'sd0, 32'h0);
      fork
         hold_results(HOLD_CYCLES);
         begin
            for (int i = 0; i < BLOCK_ENTRIES_DEF; i++)
               send_item(CMD_LOAD, 32'sd42, $urandom, 32'sd0, 32'h0);
            send_item(CMD_LOAD, 32'sd42, 32'hdead_0000, 32'sd0, 32'h0);
            for (int i = 0; i < 6; i++)
               send_item(CMD_PROBE, 32'sd42, 32'h0, $urandom, $urandom);
         end
      join
      send_item(CMD_CLEAR, 32'sd0, 32'h0, 32'sd0, 32'h0);
   endtask

   task automatic send_random_item();
      logic [CMD_W-1:0]        cmd;
      logic signed [KEY_W-1:0] key;
      int                      pick;
      pick = $urandom_range(99);
      if (pick < 40)      cmd = CMD_LOAD;
      else if (pick < 88) cmd = CMD_PROBE;
      else if (pick < 95) cmd = CMD_CLEAR;
      else                cmd = CMD_UNUSED;
      // mostly a small key pool so probes hit, sometimes extremes or anything
      pick = $urandom_range(99);
      if (pick < 85)      key = $urandom_range(7) - 4;
      else if (pick < 90) key = (pick % 2) ? KEY_MIN : KEY_MAX;
      else                key = $urandom;
      send_item(cmd, key, $urandom, $urandom, $urandom);
   endtask

   // random phases under several limits, one of them with no idling
   task automatic test_random_mix();
      logic [LIMIT_W-1:0] phase_limit [6];
      phase_limit[0] = LIMIT_RESET;
      phase_limit[1] = 6'd3;
      phase_limit[2] = 6'd0;
      phase_limit[3] = 6'd63;
      phase_limit[4] = 6'd1;
      phase_limit[5] = LIMIT_W'($urandom_range(40, 1));
      for (int p = 0; p < 6; p++) begin
         write_limit(phase_limit[p]);
         send_item(CMD_CLEAR, 32'sd0, 32'h0, 32'sd0, 32'h0);
         steady <= (p == 2);
         for (int i = 0; i < 55; i++)
            send_random_item();
         steady <= 1'b0;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_block();
      test_load_and_probe();
      test_limit_settings();
      test_block_full_pressure();
      test_random_mix();
      settle_block();
      $display("sent %0d loads, %0d probes, %0d clears, %0d unused commands, %0d limit writes",
               n_loads, n_probes, n_clears, n_ignored, n_limit_writes);
      $display("checked %0d joined rows and %0d rejected loads, %0d mismatches",
               n_rows, n_rejects, errors);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
